### sv/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared constants and saturating and magnitude helpers of the angle/bias filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

	localparam int ANGLE_W          = 32;
	localparam int TS_W             = 16;
	localparam int CFG_W            = 32;
	localparam int CFG_IDX_W        = 2;
	localparam int S_TDATA_W        = 80;
	localparam int M_TDATA_W        = 64;
	localparam int COV_WIDTH_DEF    = 48;
	localparam int SAMPLE_FRAC_DEF  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

	localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 32'd4294967;
	localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 32'd12884902;
	localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 32'd128849019;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(S64_MAX))      return S64_MAX;
		else if (s < 65'(S64_MIN)) return S64_MIN;
		else                       return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'(S64_MAX))      return S64_MAX;
		else if (s < 65'(S64_MIN)) return S64_MIN;
		else                       return s[63:0];
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)      return 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
		else                                   return v[31:0];
	endfunction

endpackage

### sv/kalman_angle_bias_filter.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state Kalman filter fusing an accelerometer angle with a gyro rate.
// ----------------------------------------------------------------------------
// One item at a time. A set-angle beat goes through the ST_OUT state, where
// it waits while an earlier result is stalled, into the output register. An
// update beat runs a microsequence on one bit-serial shift-add multiplier
// and one restoring divider: four multiplies by the time step, two by the
// innovation, four by the covariance and two gain divides, each unit op
// preceded by a setup step in ST_EXEC and followed by a rounding pass and a
// write-back pass in ST_RND, plus five add steps in ST_EXEC. The output
// register lets the next beat be taken while a result waits.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter #(
	parameter int COV_WIDTH        = kabf_pkg::COV_WIDTH_DEF,
	parameter int SAMPLE_FRAC_BITS = kabf_pkg::SAMPLE_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kabf_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [kabf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// measured_angle [31:0], gyro_rate [63:32], time_step [79:64]
	input  logic [kabf_pkg::S_TDATA_W-1:0]  s_tdata,
	// mode
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// filtered_angle [31:0], unbiased_rate [63:32]
	output logic [kabf_pkg::M_TDATA_W-1:0]  m_tdata
);
	import kabf_pkg::*;

	localparam int CNT_W  = 7;
	localparam int Y_W    = ANGLE_W + 1;
	localparam int SH_DT  = 64 - TS_W + SAMPLE_FRAC_BITS;
	localparam int SH_Y   = 64 - Y_W + 32;
	localparam int SH_C   = 64 - COV_WIDTH + 32;
	localparam logic signed [63:0] COV_MAX = (64'd1 << (COV_WIDTH - 1)) - 64'd1;
	localparam logic signed [63:0] COV_MIN = ~COV_MAX;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EXEC = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_RND  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef enum logic [4:0] {
		OP_ANG, OP_DTP, OP_IN1, OP_IN2, OP_IN3, OP_P00, OP_PX, OP_P11, OP_S,
		OP_K0, OP_K1, OP_A2, OP_B2, OP_C2, OP_C0, OP_C3, OP_C1
	} op_t;

	typedef enum logic [1:0] {
		K_DT, K_Y, K_C
	} kind_t;

	function automatic logic signed [COV_WIDTH-1:0] sat_cov(input logic signed [63:0] v);
		if (v > COV_MAX)      return COV_WIDTH'(COV_MAX);
		else if (v < COV_MIN) return COV_WIDTH'(COV_MIN);
		else                  return COV_WIDTH'(v);
	endfunction

	state_t state_q;
	op_t    op_q;
	kind_t  kind_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CFG_W-1:0] apn_q, bpn_q, mn_q;
	logic signed [ANGLE_W-1:0] angle_q, bias_q, rate_q, meas_q;
	logic [TS_W-1:0] dt_q;
	logic signed [COV_WIDTH-1:0] p00_q, p01_q, p10_q, p11_q, k0_q, k1_q;
	logic signed [63:0] dtp_q, inner_q, s_q, res_q;
	logic signed [Y_W-1:0] y_q;

	logic [127:0] prod_q;
	logic [63:0]  ma_q, rem_q, quo_q, d_q;
	logic         neg_q;

	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [127:0] rsh;
	logic         rbit;
	logic [128:0] rmag;
	logic [63:0]  rmag_sat;
	logic [64:0]  msum;
	logic [64:0]  rem_ext;
	logic         div_ge;
	logic [64:0]  rem_dif;
	logic [63:0]  q_sat;
	logic [63:0]  dmag;
	logic [63:0]  nmag;
	logic [63:0]  nrem;
	logic         nneg;

	logic accept;
	logic signed [ANGLE_W-1:0] in_meas, in_gyro;
	logic [TS_W-1:0] in_dt;

	assign in_meas  = s_tdata[ANGLE_W-1:0];
	assign in_gyro  = s_tdata[2*ANGLE_W-1:ANGLE_W];
	assign in_dt    = s_tdata[2*ANGLE_W+TS_W-1:2*ANGLE_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		case (kind_q)
			K_DT: begin
				rsh  = prod_q >> SH_DT;
				rbit = prod_q[SH_DT-1];
			end
			K_Y: begin
				rsh  = prod_q >> SH_Y;
				rbit = prod_q[SH_Y-1];
			end
			default: begin
				rsh  = prod_q >> SH_C;
				rbit = prod_q[SH_C-1];
			end
		endcase
		rmag     = {1'b0, rsh} + 129'(rbit);
		rmag_sat = (rmag > 129'(S64_MAX)) ? 64'(S64_MAX) : rmag[63:0];
		msum     = {1'b0, prod_q[127:64]} + (prod_q[0] ? {1'b0, ma_q} : 65'd0);
		rem_ext  = {rem_q, quo_q[63]};
		div_ge   = rem_ext >= {1'b0, d_q};
		rem_dif  = rem_ext - {1'b0, d_q};
		q_sat    = quo_q[63] ? 64'(S64_MAX) : quo_q;
		dmag     = mag64(s_q);
		nmag     = (op_q == OP_K0) ? mag64(64'(p00_q)) : mag64(64'(p10_q));
		nneg     = ((op_q == OP_K0) ? p00_q[COV_WIDTH-1] : p10_q[COV_WIDTH-1]) ^ s_q[63];
		nrem     = {32'd0, nmag[63:32]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apn_q <= ANGLE_NOISE_RST;
			bpn_q <= BIAS_NOISE_RST;
			mn_q  <= MEAS_NOISE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ANGLE_NOISE: apn_q <= cfg_data;
				CFG_BIAS_NOISE:  bpn_q <= cfg_data;
				CFG_MEAS_NOISE:  mn_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_ANG;
			kind_q     <= K_DT;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			angle_q    <= '0;
			bias_q     <= '0;
			rate_q     <= '0;
			p00_q      <= '0;
			p01_q      <= '0;
			p10_q      <= '0;
			p11_q      <= '0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						meas_q <= in_meas;
						dt_q   <= in_dt;
						op_q   <= OP_ANG;
						if (s_tuser) begin
							angle_q <= in_meas;
							state_q <= ST_OUT;
						end else begin
							rate_q  <= sat32(64'(in_gyro) - 64'(bias_q));
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					state_q <= ST_MUL;
					prod_q  <= {64'd0, 64'(dt_q)};
					kind_q  <= K_DT;
					cnt_q   <= CNT_W'(TS_W);
					neg_q   <= 1'b0;
					case (op_q)
						OP_ANG: begin
							ma_q  <= mag64(64'(rate_q));
							neg_q <= rate_q[ANGLE_W-1];
						end
						OP_DTP: begin
							ma_q  <= mag64(64'(p11_q));
							neg_q <= p11_q[COV_WIDTH-1];
						end
						OP_IN1: begin
							inner_q <= sat_sub64(dtp_q, 64'(p01_q));
							op_q    <= OP_IN2;
							state_q <= ST_EXEC;
						end
						OP_IN2: begin
							inner_q <= sat_sub64(inner_q, 64'(p10_q));
							op_q    <= OP_IN3;
							state_q <= ST_EXEC;
						end
						OP_IN3: begin
							inner_q <= sat_add64(inner_q, 64'(apn_q));
							op_q    <= OP_P00;
							state_q <= ST_EXEC;
						end
						OP_P00: begin
							ma_q  <= mag64(inner_q);
							neg_q <= inner_q[63];
						end
						OP_PX: begin
							p01_q   <= sat_cov(sat_sub64(64'(p01_q), dtp_q));
							p10_q   <= sat_cov(sat_sub64(64'(p10_q), dtp_q));
							op_q    <= OP_P11;
							state_q <= ST_EXEC;
						end
						OP_P11: begin
							ma_q <= 64'(bpn_q);
						end
						OP_S: begin
							s_q     <= sat_add64(64'(p00_q), 64'(mn_q));
							y_q     <= Y_W'(meas_q) - Y_W'(angle_q);
							op_q    <= OP_K0;
							state_q <= ST_EXEC;
						end
						OP_K0, OP_K1: begin
							d_q   <= dmag;
							neg_q <= nneg;
							rem_q <= nrem;
							quo_q <= {nmag[31:0], 32'd0};
							cnt_q <= CNT_W'(64);
							if (dmag == 64'd0) begin
								res_q   <= '0;
								state_q <= ST_RND;
							end else if (nrem >= dmag) begin
								res_q   <= nneg ? S64_MIN : S64_MAX;
								state_q <= ST_RND;
							end else begin
								state_q <= ST_DIV;
							end
						end
						OP_A2, OP_B2: begin
							ma_q   <= (op_q == OP_A2) ? mag64(64'(k0_q)) : mag64(64'(k1_q));
							neg_q  <= ((op_q == OP_A2) ? k0_q[COV_WIDTH-1] : k1_q[COV_WIDTH-1])
								^ y_q[Y_W-1];
							prod_q <= {64'd0, mag64(64'(y_q))};
							kind_q <= K_Y;
							cnt_q  <= CNT_W'(Y_W);
						end
						default: begin
							ma_q   <= (op_q == OP_C0 || op_q == OP_C1) ?
								mag64(64'(k0_q)) : mag64(64'(k1_q));
							neg_q  <= ((op_q == OP_C0 || op_q == OP_C1) ?
								k0_q[COV_WIDTH-1] : k1_q[COV_WIDTH-1]) ^
								((op_q == OP_C0 || op_q == OP_C2) ?
								p00_q[COV_WIDTH-1] : p01_q[COV_WIDTH-1]);
							prod_q <= {64'd0, (op_q == OP_C0 || op_q == OP_C2) ?
								mag64(64'(p00_q)) : mag64(64'(p01_q))};
							kind_q <= K_C;
							cnt_q  <= CNT_W'(COV_WIDTH);
						end
					endcase
				end
				ST_MUL: begin
					prod_q <= {msum, prod_q[63:1]};
					if (cnt_q == CNT_W'(1)) state_q <= ST_RND;
					else                    cnt_q   <= cnt_q - CNT_W'(1);
				end
				ST_DIV: begin
					if (div_ge) rem_q <= rem_dif[63:0];
					else        rem_q <= rem_ext[63:0];
					quo_q <= {quo_q[62:0], div_ge};
					if (cnt_q == CNT_W'(1)) state_q <= ST_RND;
					else                    cnt_q   <= cnt_q - CNT_W'(1);
				end
				ST_RND: begin
					// res_q is registered in this pass: write back in the next pass
					if (op_q == OP_K0 || op_q == OP_K1) begin
						if (cnt_q == CNT_W'(1))
							res_q <= neg_q ? -$signed(q_sat) : $signed(q_sat);
					end else begin
						res_q <= neg_q ? -$signed(rmag_sat) : $signed(rmag_sat);
					end
					cnt_q   <= '0;
					state_q <= (cnt_q == '0) ? ST_OUT : ST_RND;
					if (cnt_q == '0) begin
						state_q <= ST_EXEC;
						op_q    <= op_t'(op_q + 5'd1);
						case (op_q)
							OP_ANG: angle_q <= sat32(sat_add64(64'(angle_q), res_q));
							OP_DTP: begin
								dtp_q <= res_q;
								op_q  <= OP_IN1;
							end
							OP_P00: begin
								p00_q <= sat_cov(sat_add64(64'(p00_q), res_q));
								op_q  <= OP_PX;
							end
							OP_P11: begin
								p11_q <= sat_cov(sat_add64(64'(p11_q), res_q));
								op_q  <= OP_S;
							end
							OP_K0:  k0_q <= sat_cov(res_q);
							OP_K1:  k1_q <= sat_cov(res_q);
							OP_A2:  angle_q <= sat32(sat_add64(64'(angle_q), res_q));
							OP_B2:  bias_q  <= sat32(sat_add64(64'(bias_q), res_q));
							OP_C2:  p10_q <= sat_cov(sat_sub64(64'(p10_q), res_q));
							OP_C0:  p00_q <= sat_cov(sat_sub64(64'(p00_q), res_q));
							OP_C3:  p11_q <= sat_cov(sat_sub64(64'(p11_q), res_q));
							OP_C1: begin
								p01_q   <= sat_cov(sat_sub64(64'(p01_q), res_q));
								state_q <= ST_OUT;
							end
							default: ;
						endcase
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {rate_q, angle_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/kabf_checker.sv
// ----------------------------------------------------------------------------
// kabf_checker
// Port-level checks of the angle/bias filter, bound to the top level.
// ----------------------------------------------------------------------------
module kabf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [kabf_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [kabf_pkg::M_TDATA_W-1:0] m_tdata
);
	import kabf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !s_tready)
		else $error("update beat taken while a filter update runs");

	a_set_angle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser && !m_tvalid |-> ##2
		(m_tvalid && m_tdata[31:0] == $past(s_tdata[31:0], 2)))
		else $error("set-angle beat did not return the loaded angle");

	a_free_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("input not ready once a result is posted");

endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (.*);
